FILE: hw/rtl/gbtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbtc_pkg: shared types and constants of the gap buffer cursor engine
// Holds sizes, opcodes, micro-operation codes, the command and status
// structs between controller and datapath, and the UTF-8 length function.
// ----------------------------------------------------------------------------
package gbtc_pkg;

    localparam int CAPACITY = 4096;
    localparam int ADDR_W   = 12;   // store address bits
    localparam int POS_W    = 13;   // offsets and lengths, 0..CAPACITY
    localparam int COL_W    = 17;   // running column
    localparam int GOAL_W   = 16;   // stored goal column
    localparam int TAB_W    = 4;

    localparam logic [TAB_W-1:0] TAB_RESET = 4'd4;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_TAB = 8'h09;

    // Opcodes
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_ERASE  = 3'd1;
    localparam logic [2:0] OP_LEFT   = 3'd2;
    localparam logic [2:0] OP_RIGHT  = 3'd3;
    localparam logic [2:0] OP_UP     = 3'd4;
    localparam logic [2:0] OP_DOWN   = 3'd5;
    localparam logic [2:0] OP_READ   = 3'd6;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BEYOND = 2'd2;

    typedef logic [2:0] t_rd_sel;
    localparam t_rd_sel RD_NONE = 3'd0;
    localparam t_rd_sel RD_OFF  = 3'd1;
    localparam t_rd_sel RD_OFFM1 = 3'd2;
    localparam t_rd_sel RD_ROFF = 3'd3;
    localparam t_rd_sel RD_MOVL = 3'd4;
    localparam t_rd_sel RD_MOVR = 3'd5;

    typedef logic [1:0] t_wr_sel;
    localparam t_wr_sel WR_NONE = 2'd0;
    localparam t_wr_sel WR_MOVL = 2'd1;
    localparam t_wr_sel WR_MOVR = 2'd2;
    localparam t_wr_sel WR_INS  = 2'd3;

    typedef logic [2:0] t_off_op;
    localparam t_off_op OFF_HOLD  = 3'd0;
    localparam t_off_op OFF_CUR   = 3'd1;
    localparam t_off_op OFF_CURM1 = 3'd2;
    localparam t_off_op OFF_DEC   = 3'd3;
    localparam t_off_op OFF_INC   = 3'd4;
    localparam t_off_op OFF_STEP  = 3'd5;
    localparam t_off_op OFF_TGT   = 3'd6;

    typedef logic [1:0] t_two_op;
    localparam t_two_op X_HOLD = 2'd0;
    localparam t_two_op X_A    = 2'd1;   // cur: inc, len: inc, gs: inc, col: clear
    localparam t_two_op X_B    = 2'd2;   // cur: off, len: erase, gs: dec, col: advance

    typedef logic [1:0] t_tgt_op;
    localparam t_tgt_op TGT_HOLD  = 2'd0;
    localparam t_tgt_op TGT_OFF   = 2'd1;
    localparam t_tgt_op TGT_OFFM1 = 2'd2;

    typedef logic [1:0] t_st_op;
    localparam t_st_op STO_HOLD   = 2'd0;
    localparam t_st_op STO_FULL   = 2'd1;
    localparam t_st_op STO_BEYOND = 2'd2;
    localparam t_st_op STO_RDATA  = 2'd3;

    typedef struct packed {
        logic    load;
        logic    push;
        t_rd_sel rd_sel;
        t_wr_sel wr_sel;
        t_off_op off_op;
        t_two_op col_op;
        t_two_op cur_op;
        t_two_op len_op;
        t_two_op gs_op;
        t_tgt_op tgt_op;
        logic    goal_set;
        t_st_op  st_op;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic full;
        logic cur_zero;
        logic cur_lt_len;
        logic off_zero;
        logic off_lt_len;
        logic off_lt_cur;
        logic off_lt_tgt;
        logic col_lt_goal;
        logic gs_gt_cur;
        logic gs_lt_cur;
        logic byte_nl;
        logic byte_cont;
        logic goal_known;
        logic roff_lt_len;
    } t_stat;

    function automatic logic [2:0] char_len(input logic [7:0] c);
        if (c < 8'h80)                    return 3'd1;
        else if (c >= 8'hC0 && c <= 8'hDF) return 3'd2;
        else if (c >= 8'hE0 && c <= 8'hEF) return 3'd3;
        else if (c >= 8'hF0 && c <= 8'hF7) return 3'd4;
        else                               return 3'd1;
    endfunction

endpackage

FILE: hw/rtl/gbtc_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbtc_dpath: text store and cursor datapath
// Gap buffer memory with logical-to-physical mapping, cursor, length, gap,
// scan offset, column counter, goal column and the result register.
// ----------------------------------------------------------------------------
module gbtc_dpath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  gbtc_pkg::t_cmd             i_cmd,
    output gbtc_pkg::t_stat            o_stat,
    input  logic [23:0]                i_in_data,
    input  logic                       i_cfg_we,
    input  logic [gbtc_pkg::TAB_W-1:0] i_cfg_data,
    output logic [55:0]                o_out_data
);

    localparam int AW = gbtc_pkg::ADDR_W;
    localparam int PW = gbtc_pkg::POS_W;
    localparam int CW = gbtc_pkg::COL_W;
    localparam int GW = gbtc_pkg::GOAL_W;

    logic [7:0]    r_mem [gbtc_pkg::CAPACITY];
    logic [7:0]    r_byte;
    logic [PW-1:0] r_cur, n_cur, r_len, n_len, r_gs, n_gs;
    logic [PW-1:0] r_off, n_off, r_tgt, n_tgt;
    logic [CW-1:0] r_col, n_col;
    logic [gbtc_pkg::TAB_W-1:0] r_rem, n_rem, r_tab;
    logic [GW-1:0] r_goal, n_goal;
    logic          r_gv, n_gv;
    logic [2:0]    r_op;
    logic [7:0]    r_bv, r_rdata, n_rdata;
    logic [AW-1:0] r_roff;
    logic [1:0]    r_status, n_status;
    logic [55:0]   r_out;

    logic [AW-1:0] w_gap, w_ra, w_wa;
    logic [PW-1:0] w_la, w_clen, w_room, w_cut, w_off_clamp;
    logic [gbtc_pkg::TAB_W-1:0] w_tw;
    logic [gbtc_pkg::TAB_W:0]   w_rem1;
    logic [7:0]    w_wd;
    logic          w_rd_en, w_wr_en;

    // Bytes at or after the gap start sit past the gap, CAPACITY-len further on.
    assign w_gap  = AW'(PW'(gbtc_pkg::CAPACITY) - r_len);
    assign w_clen = PW'(gbtc_pkg::char_len(r_byte));
    assign w_tw   = (r_tab == '0) ? gbtc_pkg::TAB_W'(1) : r_tab;
    assign w_rem1 = {1'b0, r_rem} + 1'b1;
    assign w_off_clamp = (r_off > r_len) ? r_len : r_off;
    assign w_room = r_len - r_cur;
    assign w_cut  = (w_clen > w_room) ? w_room : w_clen;

    always_comb begin
        w_la    = r_off;
        w_rd_en = 1'b1;
        unique case (i_cmd.rd_sel)
            gbtc_pkg::RD_OFFM1: w_la = r_off - 1'b1;
            gbtc_pkg::RD_ROFF:  w_la = {1'b0, r_roff};
            gbtc_pkg::RD_OFF:   w_la = r_off;
            default:            w_rd_en = (i_cmd.rd_sel != gbtc_pkg::RD_NONE);
        endcase
        if (i_cmd.rd_sel == gbtc_pkg::RD_MOVL) begin
            w_ra = r_gs[AW-1:0] - 1'b1;
        end else if (i_cmd.rd_sel == gbtc_pkg::RD_MOVR) begin
            w_ra = r_gs[AW-1:0] + w_gap;
        end else begin
            w_ra = (w_la < r_gs) ? w_la[AW-1:0] : w_la[AW-1:0] + w_gap;
        end
    end

    always_comb begin
        w_wr_en = 1'b1;
        w_wa    = r_gs[AW-1:0];
        w_wd    = r_byte;
        unique case (i_cmd.wr_sel)
            gbtc_pkg::WR_MOVL: w_wa = r_gs[AW-1:0] - 1'b1 + w_gap;
            gbtc_pkg::WR_MOVR: w_wa = r_gs[AW-1:0];
            gbtc_pkg::WR_INS:  w_wd = r_bv;
            default:           w_wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[w_wa] <= w_wd;
        if (w_rd_en) r_byte <= r_mem[w_ra];
    end

    always_comb begin
        n_cur = r_cur;
        n_len = r_len;
        n_gs  = r_gs;
        n_off = r_off;
        n_tgt = r_tgt;
        n_col = r_col;
        n_rem = r_rem;
        n_goal = r_goal;
        n_gv  = r_gv;
        n_rdata  = r_rdata;
        n_status = r_status;

        unique case (i_cmd.cur_op)
            gbtc_pkg::X_A: n_cur = r_cur + 1'b1;
            gbtc_pkg::X_B: n_cur = w_off_clamp;
            default:       n_cur = r_cur;
        endcase
        unique case (i_cmd.len_op)
            gbtc_pkg::X_A: n_len = r_len + 1'b1;
            gbtc_pkg::X_B: n_len = r_len - w_cut;
            default:       n_len = r_len;
        endcase
        unique case (i_cmd.gs_op)
            gbtc_pkg::X_A: n_gs = r_gs + 1'b1;
            gbtc_pkg::X_B: n_gs = r_gs - 1'b1;
            default:       n_gs = r_gs;
        endcase
        unique case (i_cmd.off_op)
            gbtc_pkg::OFF_CUR:   n_off = r_cur;
            gbtc_pkg::OFF_CURM1: n_off = r_cur - 1'b1;
            gbtc_pkg::OFF_DEC:   n_off = r_off - 1'b1;
            gbtc_pkg::OFF_INC:   n_off = r_off + 1'b1;
            gbtc_pkg::OFF_STEP:  n_off = r_off + w_clen;
            gbtc_pkg::OFF_TGT:   n_off = r_tgt;
            default:             n_off = r_off;
        endcase
        unique case (i_cmd.tgt_op)
            gbtc_pkg::TGT_OFF:   n_tgt = r_off;
            gbtc_pkg::TGT_OFFM1: n_tgt = r_off - 1'b1;
            default:             n_tgt = r_tgt;
        endcase
        // The remainder tracks col modulo the tab width, so a tab needs no divider.
        unique case (i_cmd.col_op)
            gbtc_pkg::X_A: begin
                n_col = '0;
                n_rem = '0;
            end
            gbtc_pkg::X_B: begin
                if (r_byte == gbtc_pkg::CH_TAB) begin
                    n_col = r_col + CW'(w_tw - r_rem);
                    n_rem = '0;
                end else begin
                    n_col = r_col + 1'b1;
                    n_rem = (w_rem1 == {1'b0, w_tw}) ? '0 : w_rem1[gbtc_pkg::TAB_W-1:0];
                end
            end
            default: begin
                n_col = r_col;
                n_rem = r_rem;
            end
        endcase
        if (i_cmd.goal_set) begin
            n_goal = (r_col[CW-1:GW] != '0) ? {GW{1'b1}} : r_col[GW-1:0];
            n_gv   = 1'b1;
        end
        unique case (i_cmd.st_op)
            gbtc_pkg::STO_FULL:   n_status = gbtc_pkg::ST_FULL;
            gbtc_pkg::STO_BEYOND: n_status = gbtc_pkg::ST_BEYOND;
            gbtc_pkg::STO_RDATA:  n_rdata  = r_byte;
            default:              n_status = r_status;
        endcase
        if (i_cmd.load) begin
            n_status = gbtc_pkg::ST_OK;
            n_rdata  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= '0;
            r_len  <= '0;
            r_gs   <= '0;
            r_goal <= '0;
            r_gv   <= 1'b0;
            r_tab  <= gbtc_pkg::TAB_RESET;
            r_col  <= '0;
            r_rem  <= '0;
        end else begin
            r_cur  <= n_cur;
            r_len  <= n_len;
            r_gs   <= n_gs;
            r_goal <= n_goal;
            r_gv   <= n_gv;
            r_col  <= n_col;
            r_rem  <= n_rem;
            if (i_cfg_we) r_tab <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_off    <= n_off;
        r_tgt    <= n_tgt;
        r_rdata  <= n_rdata;
        r_status <= n_status;
        if (i_cmd.load) begin
            r_op   <= i_in_data[2:0];
            r_bv   <= i_in_data[10:3];
            r_roff <= i_in_data[22:11];
        end
        if (i_cmd.push) begin
            r_out <= {3'b000, r_status, r_rdata, r_gv, r_goal, r_len, r_cur};
        end
    end

    assign o_out_data = r_out;

    assign o_stat.op          = r_op;
    assign o_stat.full        = (r_len >= PW'(gbtc_pkg::CAPACITY));
    assign o_stat.cur_zero    = (r_cur == '0);
    assign o_stat.cur_lt_len  = (r_cur < r_len);
    assign o_stat.off_zero    = (r_off == '0);
    assign o_stat.off_lt_len  = (r_off < r_len);
    assign o_stat.off_lt_cur  = (r_off < r_cur);
    assign o_stat.off_lt_tgt  = (r_off < r_tgt);
    assign o_stat.col_lt_goal = (r_col < CW'(r_goal));
    assign o_stat.gs_gt_cur   = (r_gs > r_cur);
    assign o_stat.gs_lt_cur   = (r_gs < r_cur);
    assign o_stat.byte_nl     = (r_byte == gbtc_pkg::CH_NL);
    assign o_stat.byte_cont   = (r_byte[7:6] == 2'b10);
    assign o_stat.goal_known  = r_gv;
    assign o_stat.roff_lt_len = ({1'b0, r_roff} < r_len);

    a_cur_in_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur <= r_len) && (r_gs <= r_len))
        else $error("cursor or gap start beyond text length");
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= PW'(gbtc_pkg::CAPACITY))
        else $error("text length beyond capacity");
    a_ins_at_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_sel == gbtc_pkg::WR_INS) |-> (r_gs == r_cur))
        else $error("insert written away from the cursor");
    a_ins_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_sel == gbtc_pkg::WR_INS) |=> (r_len == $past(r_len) + 1'b1))
        else $error("insert did not grow the text");

endmodule

FILE: hw/rtl/gbtc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbtc_ctrl: operation sequencer
// State machine that steps the datapath through gap moves, line scans,
// column counts and vertical moves, and owns the input and output handshake.
// ----------------------------------------------------------------------------
module gbtc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  gbtc_pkg::t_stat i_stat,
    output gbtc_pkg::t_cmd  o_cmd
);

    localparam logic [5:0] S_IDLE     = 6'd0;
    localparam logic [5:0] S_DISPATCH = 6'd1;
    localparam logic [5:0] S_GAP      = 6'd2;
    localparam logic [5:0] S_GAP_WL   = 6'd3;
    localparam logic [5:0] S_GAP_WR   = 6'd4;
    localparam logic [5:0] S_INS      = 6'd5;
    localparam logic [5:0] S_ERASE_RD = 6'd6;
    localparam logic [5:0] S_ERASE_DO = 6'd7;
    localparam logic [5:0] S_LEFT_CHK = 6'd8;
    localparam logic [5:0] S_LEFT_W   = 6'd9;
    localparam logic [5:0] S_LEFT_SET = 6'd10;
    localparam logic [5:0] S_RIGHT_RD = 6'd11;
    localparam logic [5:0] S_RIGHT_DO = 6'd12;
    localparam logic [5:0] S_RIGHT_SET = 6'd13;
    localparam logic [5:0] S_LB       = 6'd14;
    localparam logic [5:0] S_LB_W     = 6'd15;
    localparam logic [5:0] S_LB_DONE  = 6'd16;
    localparam logic [5:0] S_SG_START = 6'd17;
    localparam logic [5:0] S_CF       = 6'd18;
    localparam logic [5:0] S_CF_W     = 6'd19;
    localparam logic [5:0] S_SG_RET   = 6'd20;
    localparam logic [5:0] S_UP_PREP  = 6'd21;
    localparam logic [5:0] S_UP_LOOP  = 6'd22;
    localparam logic [5:0] S_UP_W     = 6'd23;
    localparam logic [5:0] S_NLB      = 6'd24;
    localparam logic [5:0] S_NLB_W    = 6'd25;
    localparam logic [5:0] S_NLB_DONE = 6'd26;
    localparam logic [5:0] S_DN_PREP  = 6'd27;
    localparam logic [5:0] S_DN_LOOP  = 6'd28;
    localparam logic [5:0] S_DN_W     = 6'd29;
    localparam logic [5:0] S_READ_RD  = 6'd30;
    localparam logic [5:0] S_READ_W   = 6'd31;
    localparam logic [5:0] S_FINISH   = 6'd32;

    // What a finished line-begin scan feeds.
    localparam logic [1:0] PH_SG  = 2'd0;
    localparam logic [1:0] PH_UP1 = 2'd1;
    localparam logic [1:0] PH_UP2 = 2'd2;

    logic [5:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_phase = r_phase;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.op)
                    gbtc_pkg::OP_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.st_op = gbtc_pkg::STO_FULL;
                            n_state     = S_FINISH;
                        end else begin
                            n_state = S_GAP;
                        end
                    end
                    gbtc_pkg::OP_ERASE: begin
                        o_cmd.off_op = gbtc_pkg::OFF_CUR;
                        n_state = i_stat.cur_lt_len ? S_GAP : S_FINISH;
                    end
                    gbtc_pkg::OP_LEFT: begin
                        o_cmd.off_op = gbtc_pkg::OFF_CURM1;
                        n_state = i_stat.cur_zero ? S_FINISH : S_LEFT_CHK;
                    end
                    gbtc_pkg::OP_RIGHT: begin
                        o_cmd.off_op = gbtc_pkg::OFF_CUR;
                        n_state = i_stat.cur_lt_len ? S_RIGHT_RD : S_FINISH;
                    end
                    gbtc_pkg::OP_UP: begin
                        o_cmd.off_op = gbtc_pkg::OFF_CUR;
                        n_phase = PH_UP1;
                        n_state = S_LB;
                    end
                    gbtc_pkg::OP_DOWN: begin
                        o_cmd.off_op = gbtc_pkg::OFF_CUR;
                        n_state = S_NLB;
                    end
                    gbtc_pkg::OP_READ: begin
                        if (i_stat.roff_lt_len) begin
                            n_state = S_READ_RD;
                        end else begin
                            o_cmd.st_op = gbtc_pkg::STO_BEYOND;
                            n_state     = S_FINISH;
                        end
                    end
                    default: n_state = S_FINISH;
                endcase
            end
            S_GAP: begin
                priority if (i_stat.gs_gt_cur) begin
                    o_cmd.rd_sel = gbtc_pkg::RD_MOVL;
                    n_state = S_GAP_WL;
                end else if (i_stat.gs_lt_cur) begin
                    o_cmd.rd_sel = gbtc_pkg::RD_MOVR;
                    n_state = S_GAP_WR;
                end else begin
                    n_state = (i_stat.op == gbtc_pkg::OP_INSERT) ? S_INS : S_ERASE_RD;
                end
            end
            S_GAP_WL: begin
                o_cmd.wr_sel = gbtc_pkg::WR_MOVL;
                o_cmd.gs_op  = gbtc_pkg::X_B;
                n_state = S_GAP;
            end
            S_GAP_WR: begin
                o_cmd.wr_sel = gbtc_pkg::WR_MOVR;
                o_cmd.gs_op  = gbtc_pkg::X_A;
                n_state = S_GAP;
            end
            S_INS: begin
                o_cmd.wr_sel = gbtc_pkg::WR_INS;
                o_cmd.gs_op  = gbtc_pkg::X_A;
                o_cmd.cur_op = gbtc_pkg::X_A;
                o_cmd.len_op = gbtc_pkg::X_A;
                n_state = S_SG_START;
            end
            S_ERASE_RD: begin
                o_cmd.rd_sel = gbtc_pkg::RD_OFF;
                n_state = S_ERASE_DO;
            end
            S_ERASE_DO: begin
                o_cmd.len_op = gbtc_pkg::X_B;
                n_state = S_FINISH;
            end
            S_LEFT_CHK: begin
                if (i_stat.off_zero) begin
                    n_state = S_LEFT_SET;
                end else begin
                    o_cmd.rd_sel = gbtc_pkg::RD_OFF;
                    n_state = S_LEFT_W;
                end
            end
            S_LEFT_W: begin
                if (i_stat.byte_cont) begin
                    o_cmd.off_op = gbtc_pkg::OFF_DEC;
                    n_state = S_LEFT_CHK;
                end else begin
                    n_state = S_LEFT_SET;
                end
            end
            S_LEFT_SET, S_RIGHT_SET: begin
                o_cmd.cur_op = gbtc_pkg::X_B;
                n_state = S_SG_START;
            end
            S_RIGHT_RD: begin
                o_cmd.rd_sel = gbtc_pkg::RD_OFF;
                n_state = S_RIGHT_DO;
            end
            S_RIGHT_DO: begin
                o_cmd.off_op = gbtc_pkg::OFF_STEP;
                n_state = S_RIGHT_SET;
            end
            S_LB: begin
                if (i_stat.off_zero) begin
                    n_state = S_LB_DONE;
                end else begin
                    o_cmd.rd_sel = gbtc_pkg::RD_OFFM1;
                    n_state = S_LB_W;
                end
            end
            S_LB_W: begin
                if (i_stat.byte_nl) begin
                    n_state = S_LB_DONE;
                end else begin
                    o_cmd.off_op = gbtc_pkg::OFF_DEC;
                    n_state = S_LB;
                end
            end
            S_LB_DONE: begin
                unique case (r_phase)
                    PH_SG: begin
                        o_cmd.col_op = gbtc_pkg::X_A;
                        n_state = S_CF;
                    end
                    PH_UP1: begin
                        o_cmd.tgt_op = gbtc_pkg::TGT_OFFM1;
                        n_state = i_stat.off_zero ? S_FINISH : S_UP_PREP;
                    end
                    PH_UP2: begin
                        o_cmd.col_op = gbtc_pkg::X_A;
                        n_state = S_UP_LOOP;
                    end
                    default: n_state = S_FINISH;
                endcase
            end
            S_SG_START: begin
                o_cmd.off_op = gbtc_pkg::OFF_CUR;
                n_phase = PH_SG;
                n_state = S_LB;
            end
            S_CF: begin
                if (i_stat.off_lt_cur) begin
                    o_cmd.rd_sel = gbtc_pkg::RD_OFF;
                    n_state = S_CF_W;
                end else begin
                    o_cmd.goal_set = 1'b1;
                    n_state = S_SG_RET;
                end
            end
            S_CF_W, S_UP_W: begin
                o_cmd.col_op = gbtc_pkg::X_B;
                o_cmd.off_op = gbtc_pkg::OFF_STEP;
                n_state = (r_state == S_CF_W) ? S_CF : S_UP_LOOP;
            end
            S_SG_RET: begin
                unique case (i_stat.op)
                    gbtc_pkg::OP_UP:   n_state = S_UP_PREP;
                    gbtc_pkg::OP_DOWN: n_state = S_DN_PREP;
                    default:           n_state = S_FINISH;
                endcase
            end
            S_UP_PREP: begin
                if (!i_stat.goal_known) begin
                    n_state = S_SG_START;
                end else begin
                    o_cmd.off_op = gbtc_pkg::OFF_TGT;
                    n_phase = PH_UP2;
                    n_state = S_LB;
                end
            end
            S_UP_LOOP: begin
                if (i_stat.off_lt_tgt && i_stat.col_lt_goal) begin
                    o_cmd.rd_sel = gbtc_pkg::RD_OFF;
                    n_state = S_UP_W;
                end else begin
                    o_cmd.cur_op = gbtc_pkg::X_B;
                    n_state = S_FINISH;
                end
            end
            S_NLB: begin
                if (i_stat.off_lt_len) begin
                    o_cmd.rd_sel = gbtc_pkg::RD_OFF;
                    n_state = S_NLB_W;
                end else begin
                    n_state = S_NLB_DONE;
                end
            end
            S_NLB_W: begin
                o_cmd.off_op = gbtc_pkg::OFF_INC;
                n_state = i_stat.byte_nl ? S_NLB_DONE : S_NLB;
            end
            S_NLB_DONE: begin
                o_cmd.tgt_op = gbtc_pkg::TGT_OFF;
                n_state = i_stat.off_lt_len ? S_DN_PREP : S_FINISH;
            end
            S_DN_PREP: begin
                if (!i_stat.goal_known) begin
                    n_state = S_SG_START;
                end else begin
                    o_cmd.off_op = gbtc_pkg::OFF_TGT;
                    o_cmd.col_op = gbtc_pkg::X_A;
                    n_state = S_DN_LOOP;
                end
            end
            S_DN_LOOP: begin
                if (i_stat.off_lt_len) begin
                    o_cmd.rd_sel = gbtc_pkg::RD_OFF;
                    n_state = S_DN_W;
                end else begin
                    o_cmd.cur_op = gbtc_pkg::X_B;
                    n_state = S_FINISH;
                end
            end
            S_DN_W: begin
                if (i_stat.byte_nl || !i_stat.col_lt_goal) begin
                    o_cmd.cur_op = gbtc_pkg::X_B;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.col_op = gbtc_pkg::X_B;
                    o_cmd.off_op = gbtc_pkg::OFF_STEP;
                    n_state = S_DN_LOOP;
                end
            end
            S_READ_RD: begin
                o_cmd.rd_sel = gbtc_pkg::RD_ROFF;
                n_state = S_READ_W;
            end
            S_READ_W: begin
                o_cmd.st_op = gbtc_pkg::STO_RDATA;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.push) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_SG;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_push_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");
    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_DISPATCH))
        else $error("accepted beat did not start an operation");
    a_push_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |=> (r_out_valid && r_state == S_IDLE))
        else $error("result push did not raise valid");

endmodule

FILE: hw/rtl/gap_buffer_text_cursor_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_buffer_text_cursor_engine: UTF-8 text editor core on a gap buffer
// One input beat is one edit or cursor operation; one result beat follows
// with cursor, length, goal column, read byte and status.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  opcode, byte_value, read_offset
// m_axis    out  m_axis_tvalid / m_axis_tready  cursor, length, goal, read data, status
// cfg       in   i_cfg_valid / o_cfg_ready      tab stop width
//
// A no-op, a refused insert or a read past the text passes through accept, dispatch and
// result; a read inside the text also passes through its read and read-wait steps.
// Sliding the gap to the cursor for insert and erase, and every line walk (line start,
// column count, vertical target), take a step that issues the read and a step that uses
// the byte for each byte or character visited, since each access goes through the single
// registered read port of the text store. Reset is synchronous and active low and leaves
// the store uncleared; a stalled output holds the engine in its final step, and one
// finished result can wait while the next beat is accepted.
module gap_buffer_text_cursor_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] opcode, [10:3] byte_value, [22:11] read_offset, [23] zero
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [12:0] cursor_offset, [25:13] text_length, [41:26] goal_column,
    // [42] goal_known, [50:43] read_data, [52:51] status, [55:53] zero
    output logic [55:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data
);

    gbtc_pkg::t_cmd  w_cmd;
    gbtc_pkg::t_stat w_stat;

    // The tab width register, always writable, must be changed only while idle by users.
    assign o_cfg_ready = 1'b1;

    gbtc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    gbtc_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_in_data  (s_axis_tdata),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_out_data (m_axis_tdata)
    );

endmodule
